### rtl/core/local_minimum_3x3_detector_assert.svh
// Assertion macros for the 3x3 local minimum detector.
`ifndef LOCAL_MINIMUM_3X3_DETECTOR_ASSERT_SVH
`define LOCAL_MINIMUM_3X3_DETECTOR_ASSERT_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define LMD_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define LMD_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lmd_pkg.sv
// Shared types and constants of the 3x3 local minimum detector.
package lmd_pkg;

	// Fixed field widths and the reset side length
	localparam int COORD_W    = 8;
	localparam int SIDE_W     = 9;
	localparam int SIDE_RESET = 16;

	// Which rows and columns of the window a decision job covers
	typedef struct packed {
		logic row_lo;	// row r-1 is decided
		logic row_hi;	// row r is decided (last row)
		logic col_lo;	// column c-1 is decided
		logic col_hi;	// column c is decided (last column)
	} lmd_flags_t;

endpackage

### rtl/core/lmd_if.sv
// Valid/ready stream interfaces for pixel items and decision items.
interface lmd_pix_if #(
	parameter int PIXEL_WIDTH = 8
);
	logic                   valid;
	logic                   ready;
	logic [PIXEL_WIDTH-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

interface lmd_res_if import lmd_pkg::*; #(
	parameter int PIXEL_WIDTH = 8
);
	logic                   valid;
	logic                   ready;
	logic [COORD_W-1:0]     center_row;
	logic [COORD_W-1:0]     center_col;
	logic [PIXEL_WIDTH-1:0] center_value;
	logic                   is_minimum;
	logic                   last_of_run;

	modport source (output valid, output center_row, output center_col,
		output center_value, output is_minimum, output last_of_run, input ready);
	modport sink   (input valid, input center_row, input center_col,
		input center_value, input is_minimum, input last_of_run, output ready);
endinterface

### rtl/core/lmd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module lmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

### rtl/core/lmd_window.sv
// Raster counters, line store read-modify-write and the 3x3 window registers.
module lmd_window import lmd_pkg::*; #(
	parameter int MAX_SIDE = 256,
	parameter int PIXEL_WIDTH = 8,
	localparam int CW = $clog2(MAX_SIDE)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SIDE_W-1:0]      cfg_wdata,
	lmd_pix_if.sink                pixels,
	output logic                   job_valid,
	input  logic                   job_ready,
	output logic [PIXEL_WIDTH-1:0] job_win [9],
	output logic [CW-1:0]          job_row,
	output logic [CW-1:0]          job_col,
	output lmd_flags_t             job_flags
);

	localparam int PW = PIXEL_WIDTH;
	localparam int RST_SIDE = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

	logic [CW-1:0] row_q, col_q, last_q;
	logic [CW:0]   eff_side;
	logic          accept;

	logic          s1_valid, fresh_s1, fwd_s1, s1_fire, nonempty;
	logic [PW-1:0] p_s1;
	logic [CW-1:0] row_s1, col_s1;
	logic [2*PW-1:0] fwd_data_s1, hold_q, ram_rdata, line_now, line_s1;
	logic [PW-1:0] upper, middle;
	logic [PW-1:0] win_q [9];
	logic [PW-1:0] win_next [9];
	lmd_flags_t    flags;

	assign accept = pixels.valid && pixels.ready;

	// Side length: zero means one, above the store depth saturates
	always_comb begin
		if (cfg_wdata == '0) begin
			eff_side = (CW+1)'(1);
		end else if (32'(cfg_wdata) > MAX_SIDE) begin
			eff_side = (CW+1)'(MAX_SIDE);
		end else begin
			eff_side = (CW+1)'(cfg_wdata);
		end
	end

	// Raster position of the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			last_q <= CW'(RST_SIDE - 1);
		end else if (cfg_we) begin
			row_q  <= '0;
			col_q  <= '0;
			last_q <= CW'(eff_side - 1'b1);
		end else if (accept) begin
			if (col_q == last_q) begin
				col_q <= '0;
				row_q <= (row_q == last_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// One entry per column: {row two above, row just above}
	lmd_ram #(
		.WIDTH (2*PW),
		.DEPTH (MAX_SIDE)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (ram_rdata),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data ({middle, p_s1})
	);

	// Line data for the item in s1: forwarded, fresh from RAM, or held
	assign line_now = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign line_s1  = fresh_s1 ? line_now : hold_q;
	assign upper    = line_s1[2*PW-1:PW];
	assign middle   = line_s1[PW-1:0];

	// Decided rows and columns for this position
	assign flags.row_lo = (row_s1 != '0);
	assign flags.row_hi = (row_s1 == last_q);
	assign flags.col_lo = (col_s1 != '0);
	assign flags.col_hi = (col_s1 == last_q);
	assign nonempty = (flags.row_lo || flags.row_hi) && (flags.col_lo || flags.col_hi);

	assign s1_fire      = s1_valid && (!nonempty || job_ready);
	assign pixels.ready = !s1_valid || s1_fire;

	// Window after shifting in the new column
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			win_next[a*3]     = win_q[a*3+1];
			win_next[a*3 + 1] = win_q[a*3+2];
		end
		win_next[2] = upper;
		win_next[5] = middle;
		win_next[8] = p_s1;
	end

	assign job_valid = s1_valid && nonempty;
	assign job_win   = win_next;
	assign job_row   = row_s1;
	assign job_col   = col_s1;
	assign job_flags = flags;

	// s1 control and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fresh_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
				fresh_s1 <= 1'b1;
				fwd_s1   <= s1_fire && (col_s1 == col_q);
			end else begin
				fresh_s1 <= 1'b0;
				if (s1_fire) begin
					s1_valid <= 1'b0;
				end
			end
			if (s1_fire) begin
				win_q <= win_next;
			end
		end
	end

	// s1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1        <= pixels.pixel_value;
			row_s1      <= row_q;
			col_s1      <= col_q;
			fwd_data_s1 <= {middle, p_s1};
		end
		if (fresh_s1) begin
			hold_q <= line_now;
		end
	end

endmodule

### rtl/core/lmd_emit.sv
// Decision job register and sequencer that emits up to four results per job.
module lmd_emit import lmd_pkg::*; #(
	parameter int MAX_SIDE = 256,
	parameter int PIXEL_WIDTH = 8,
	localparam int CW = $clog2(MAX_SIDE)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	output logic                   job_ready,
	input  logic [PIXEL_WIDTH-1:0] job_win [9],
	input  logic [CW-1:0]          job_row,
	input  logic [CW-1:0]          job_col,
	input  lmd_flags_t             job_flags,
	lmd_res_if.source              results
);

	localparam int PW = PIXEL_WIDTH;

	logic          busy_q, x_q, y_q;
	logic [PW-1:0] win_q [9];
	logic [CW-1:0] row_q, col_q;
	lmd_flags_t    flags_q;

	logic          a_hi, b_hi, last_x, last_y, emit;
	logic [CW-1:0] cur_i, cur_j;
	logic          up_ok, dn_ok, lf_ok, rt_ok, is_min;
	logic [3:0]    cidx;
	logic [PW-1:0] center;

	logic               out_valid_q, out_min_q, out_last_q;
	logic [COORD_W-1:0] out_row_q, out_col_q;
	logic [PW-1:0]      out_val_q;

	// Current window row/column: low position first when present
	assign a_hi   = !(!x_q && flags_q.row_lo);
	assign b_hi   = !(!y_q && flags_q.col_lo);
	assign last_x = x_q || !(flags_q.row_lo && flags_q.row_hi);
	assign last_y = y_q || !(flags_q.col_lo && flags_q.col_hi);
	assign cur_i  = a_hi ? row_q : row_q - 1'b1;
	assign cur_j  = b_hi ? col_q : col_q - 1'b1;

	// Neighbor existence: below/right exist only for the inner position
	assign up_ok = (cur_i != '0);
	assign dn_ok = !a_hi;
	assign lf_ok = (cur_j != '0);
	assign rt_ok = !b_hi;

	assign cidx   = (a_hi ? 4'd6 : 4'd3) + (b_hi ? 4'd2 : 4'd1);
	assign center = win_q[cidx];

	// Strictly-less compare against every existing neighbor
	always_comb begin
		logic       ok;
		logic [3:0] nidx;
		is_min = 1'b1;
		for (int da = -1; da <= 1; da++) begin
			for (int db = -1; db <= 1; db++) begin
				ok = !(da == 0 && db == 0);
				if (da == -1) ok = ok && up_ok;
				if (da == 1)  ok = ok && dn_ok;
				if (db == -1) ok = ok && lf_ok;
				if (db == 1)  ok = ok && rt_ok;
				nidx = 4'(32'(cidx) + da*3 + db);
				if (ok) begin
					if (!(center < win_q[nidx])) begin
						is_min = 1'b0;
					end
				end
			end
		end
	end

	assign emit      = busy_q && (!out_valid_q || results.ready);
	assign job_ready = !busy_q || (emit && last_x && last_y);

	// Job sequencing and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			x_q         <= 1'b0;
			y_q         <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_valid && job_ready) begin
				busy_q <= 1'b1;
				x_q    <= 1'b0;
				y_q    <= 1'b0;
			end else if (emit) begin
				if (last_x && last_y) begin
					busy_q <= 1'b0;
				end else if (last_y) begin
					y_q <= 1'b0;
					x_q <= 1'b1;
				end else begin
					y_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Job and result payload
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			win_q   <= job_win;
			row_q   <= job_row;
			col_q   <= job_col;
			flags_q <= job_flags;
		end
		if (emit) begin
			out_row_q  <= COORD_W'(cur_i);
			out_col_q  <= COORD_W'(cur_j);
			out_val_q  <= center;
			out_min_q  <= is_min;
			out_last_q <= last_x && last_y;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.center_row   = out_row_q;
	assign results.center_col   = out_col_q;
	assign results.center_value = out_val_q;
	assign results.is_minimum   = out_min_q;
	assign results.last_of_run  = out_last_q;

endmodule

### rtl/core/local_minimum_3x3_detector.sv
// Top level of the streaming 3x3 local minimum detector.
//
//   channel   role     width                     accepted when
//   pixels    sink     PIXEL_WIDTH               valid && ready
//   results   source   8+8+PIXEL_WIDTH+1+1       valid && ready
//   cfg       write    9 (side length)           cfg_we
//
// Takes one pixel per cycle while results are taken; results leave one per cycle, so an
// item with two results (a row end past row 0, or an item of the last row between column 0
// and the last column) holds off the pixel stream while its results leave, as does the
// frame end (four results). A pixel reaches its first result through the s1 register with
// the line RAM read, the decision job register and the output register.
// Reset clears counters, control and window registers; the line RAM needs no clearing pass.
// A write to cfg restarts the frame at row 0, column 0.
`include "local_minimum_3x3_detector_assert.svh"

module local_minimum_3x3_detector import lmd_pkg::*; #(
	parameter int MAX_SIDE = 256,
	parameter int PIXEL_WIDTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIDE_W-1:0] cfg_wdata,
	lmd_pix_if.sink           pixels,
	lmd_res_if.source         results
);

	localparam int CW = $clog2(MAX_SIDE);

	logic                   job_valid, job_ready;
	logic [PIXEL_WIDTH-1:0] job_win [9];
	logic [CW-1:0]          job_row, job_col;
	lmd_flags_t             job_flags;

	// Line store and window
	lmd_window #(
		.MAX_SIDE    (MAX_SIDE),
		.PIXEL_WIDTH (PIXEL_WIDTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixels    (pixels),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_win   (job_win),
		.job_row   (job_row),
		.job_col   (job_col),
		.job_flags (job_flags)
	);

	// Decision sequencer and output register
	lmd_emit #(
		.MAX_SIDE    (MAX_SIDE),
		.PIXEL_WIDTH (PIXEL_WIDTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_win   (job_win),
		.job_row   (job_row),
		.job_col   (job_col),
		.job_flags (job_flags),
		.results   (results)
	);

	// Checks
	`LMD_ASSERT_NOW(a_job_nonempty, clk, arst_n, job_valid, (job_flags.row_lo || job_flags.row_hi) && (job_flags.col_lo || job_flags.col_hi), "decision job without results offered")
	`LMD_ASSERT_NOW(a_corner_diag, clk, arst_n, job_valid && job_flags.row_hi && job_flags.col_hi, job_row == job_col, "frame corner job off the diagonal")
	`LMD_ASSERT_NOW(a_run_holds, clk, arst_n, results.valid && !results.ready && !results.last_of_run, !job_ready, "new job taken while a run is stalled")
	`LMD_ASSERT_NEXT(a_ready_chain, clk, arst_n, pixels.valid && pixels.ready, pixels.ready == (!job_valid || job_ready), "pixel ready not tied to job handoff")

endmodule
